FILE: sv/per_group_poll_backoff_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-group poll backoff table
// Property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef PER_GROUP_POLL_BACKOFF_TABLE_ASSERT_SVH
`define PER_GROUP_POLL_BACKOFF_TABLE_ASSERT_SVH

// same-cycle implication
`define PGPB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pgpb_pkg.sv
// ----------------------------------------------------------------------------
// pgpb_pkg
// Shared types and constants of the per-group poll backoff table.
// ----------------------------------------------------------------------------
package pgpb_pkg;

  localparam logic [2:0] OP_QUERY  = 3'd0;
  localparam logic [2:0] OP_REPORT = 3'd1;
  localparam logic [2:0] OP_RESET  = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_SWEEP  = 3'd4;

  localparam logic [2:0] CFG_BASE_INTERVAL = 3'd0;
  localparam logic [2:0] CFG_EMPTY_THRESH  = 3'd1;
  localparam logic [2:0] CFG_GROWTH_FACTOR = 3'd2;
  localparam logic [2:0] CFG_MAX_INTERVAL  = 3'd3;
  localparam logic [2:0] CFG_MAX_IDLE      = 3'd4;

  localparam logic [23:0] RST_BASE_INTERVAL = 24'd100;
  localparam logic [15:0] RST_EMPTY_THRESH  = 16'd3;
  localparam logic [15:0] RST_GROWTH_FACTOR = 16'd512;
  localparam logic [23:0] RST_MAX_INTERVAL  = 24'd2000;
  localparam logic [15:0] RST_MAX_IDLE      = 16'd300;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [6:0]  EVICT_MAX = 7'd127;

  typedef struct packed {
    logic [23:0] interval;
    logic [15:0] count;
    logic [31:0] touch;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic calc;
    logic commit;
    logic grow_sel;
    logic sweep_issue;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic point;
    logic sweep;
    logic grow;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/per_group_poll_backoff_table.sv
// One item at a time. Query, report and reset: read, then commit the result;
// a grow state (one multiply stage) comes between when the interval grows.
// Commit and emit wait while the output stalls. Tick and other codes go to emit.
// Sweep: one entry memory read per cycle over GROUPS entries, then drain, emit.
// Reset clears valid bits and seconds, reloads config defaults, keeps entry memory.
// ----------------------------------------------------------------------------
// per_group_poll_backoff_table
// Per-group poll backoff table with exponential interval growth and sweep.
// ----------------------------------------------------------------------------
`include "per_group_poll_backoff_table_assert.svh"

module per_group_poll_backoff_table #(
  parameter int GROUPS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [5:0]  group_index,
  input  logic        got_messages,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] interval_ms,
  output logic        entry_found,
  output logic [6:0]  evicted_count
);

  pgpb_pkg::ctrl_cmd_t cmd;
  pgpb_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  pgpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pgpb_dpath #(
    .GROUPS (GROUPS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .group_index   (group_index),
    .got_messages  (got_messages),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .interval_ms   (interval_ms),
    .entry_found   (entry_found),
    .evicted_count (evicted_count)
  );

  `PGPB_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "item accepted while busy")
  `PGPB_ASSERT_SAME(a_sweep_only, out_valid && (evicted_count != 7'd0), !entry_found && (interval_ms == 24'd0), "evictions on a point item")
  `PGPB_ASSERT_SAME(a_evict_bound, out_valid, 32'(evicted_count) <= GROUPS, "evicted count above table size")

endmodule

FILE: sv/pgpb_ctrl.sv
// ----------------------------------------------------------------------------
// pgpb_ctrl
// Sequencer for point read-modify-write, growth step, sweep walk and result.
// ----------------------------------------------------------------------------
module pgpb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pgpb_pkg::dp_sts_t   sts,
  output pgpb_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_GROW  = 6'b000100,
    S_SWEEP = 6'b001000,
    S_DRAIN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.point) begin
            state_next = S_READ;
          end else if (sts.sweep) begin
            state_next = S_SWEEP;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_READ: begin
        cmd.calc = 1'b1;
        if (sts.grow) begin
          state_next = S_GROW;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_GROW: begin
        cmd.grow_sel = 1'b1;
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_issue = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/pgpb_dpath.sv
// ----------------------------------------------------------------------------
// pgpb_dpath
// Config registers, entry memory, valid bits, growth multiplier, sweep
// compare and result register.
// ----------------------------------------------------------------------------
module pgpb_dpath #(
  parameter int GROUPS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [2:0]          operation,
  input  logic [5:0]          group_index,
  input  logic                got_messages,
  input  pgpb_pkg::ctrl_cmd_t cmd,
  output pgpb_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         interval_ms,
  output logic                entry_found,
  output logic [6:0]          evicted_count
);

  localparam int IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [23:0] base_iv;
  logic [15:0] thresh;
  logic [15:0] factor;
  logic [23:0] max_iv;
  logic [15:0] max_idle;

  logic [IDX_W+5:0]   g_wide;
  logic [IDX_W-1:0]   in_idx;
  logic               in_range;
  logic               is_point;
  logic               is_sweep;

  logic [2:0]         op_q;
  logic [IDX_W-1:0]   idx_q;
  logic               had_q;
  logic [31:0]        seconds;

  pgpb_pkg::entry_t   mem [GROUPS];
  pgpb_pkg::entry_t   rd_q;
  pgpb_pkg::entry_t   wr_entry;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [GROUPS-1:0]  valid_q;

  logic               found;
  logic [23:0]        cur_iv;
  logic [15:0]        cur_cnt;
  logic [15:0]        cnt_inc;
  logic [39:0]        prod_q;
  logic [31:0]        prod_hi;
  logic [23:0]        grown;
  logic [23:0]        new_iv;
  logic [15:0]        new_cnt;
  logic               we_ok;
  logic               grow_req;

  logic [IDX_W-1:0]   sweep_addr;
  logic [IDX_W-1:0]   cmp_idx;
  logic               cmp_v;
  logic [31:0]        age;
  logic               evict_hit;
  logic [6:0]         evict_q;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_iv  <= pgpb_pkg::RST_BASE_INTERVAL;
      thresh   <= pgpb_pkg::RST_EMPTY_THRESH;
      factor   <= pgpb_pkg::RST_GROWTH_FACTOR;
      max_iv   <= pgpb_pkg::RST_MAX_INTERVAL;
      max_idle <= pgpb_pkg::RST_MAX_IDLE;
    end else if (cfg_valid) begin
      case (cfg_index)
        pgpb_pkg::CFG_BASE_INTERVAL: base_iv  <= cfg_data;
        pgpb_pkg::CFG_EMPTY_THRESH:  thresh   <= cfg_data[15:0];
        pgpb_pkg::CFG_GROWTH_FACTOR: factor   <= cfg_data[15:0];
        pgpb_pkg::CFG_MAX_INTERVAL:  max_iv   <= cfg_data;
        pgpb_pkg::CFG_MAX_IDLE:      max_idle <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign g_wide   = {{IDX_W{1'b0}}, group_index};
  assign in_idx   = g_wide[IDX_W-1:0];
  assign in_range = (32'(group_index) < GROUPS);
  assign is_point = in_range && ((operation == pgpb_pkg::OP_QUERY) ||
                                 (operation == pgpb_pkg::OP_REPORT) ||
                                 (operation == pgpb_pkg::OP_RESET));
  assign is_sweep = (operation == pgpb_pkg::OP_SWEEP);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= operation;
      idx_q <= in_idx;
      had_q <= got_messages;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds <= '0;
    end else if (cmd.accept && (operation == pgpb_pkg::OP_TICK)) begin
      seconds <= seconds + 32'd1;
    end
  end

  assign rd_en   = (cmd.accept && is_point) || cmd.sweep_issue;
  assign rd_addr = cmd.sweep_issue ? sweep_addr : in_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_q] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign found   = valid_q[idx_q];
  assign cur_iv  = found ? rd_q.interval : base_iv;
  assign cur_cnt = found ? rd_q.count : 16'd0;
  assign cnt_inc = (cur_cnt == pgpb_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 16'd1;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_q <= 40'(cur_iv) * 40'(factor);
    end
  end

  assign prod_hi = prod_q[39:8];
  assign grown   = (prod_hi > {8'd0, max_iv}) ? max_iv : prod_hi[23:0];

  always_comb begin
    new_iv   = cur_iv;
    new_cnt  = cur_cnt;
    we_ok    = 1'b0;
    grow_req = 1'b0;
    case (op_q)
      pgpb_pkg::OP_QUERY: begin
        we_ok = 1'b1;
      end
      pgpb_pkg::OP_REPORT: begin
        we_ok = 1'b1;
        if (had_q) begin
          new_iv  = base_iv;
          new_cnt = 16'd0;
        end else begin
          new_cnt  = cnt_inc;
          grow_req = (cnt_inc >= thresh);
          new_iv   = cmd.grow_sel ? grown : cur_iv;
        end
      end
      pgpb_pkg::OP_RESET: begin
        we_ok   = found;
        new_iv  = base_iv;
        new_cnt = 16'd0;
      end
      default: ;
    endcase
  end

  assign mem_we   = cmd.commit && we_ok;
  assign wr_entry = '{interval: new_iv, count: new_cnt, touch: seconds};

  assign age       = seconds - rd_q.touch;
  assign evict_hit = cmp_v && valid_q[cmp_idx] && (age > {16'd0, max_idle});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (mem_we) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (evict_hit) begin
        valid_q[cmp_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_v      <= 1'b0;
      sweep_addr <= '0;
      evict_q    <= '0;
    end else begin
      cmp_v <= cmd.sweep_issue;
      if (cmd.accept) begin
        sweep_addr <= '0;
        evict_q    <= '0;
      end else begin
        if (cmd.sweep_issue) begin
          sweep_addr <= sweep_addr + IDX_W'(1);
        end
        if (evict_hit && (evict_q != pgpb_pkg::EVICT_MAX)) begin
          evict_q <= evict_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_issue) begin
      cmp_idx <= sweep_addr;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      interval_ms   <= we_ok ? new_iv : 24'd0;
      entry_found   <= found;
      evicted_count <= 7'd0;
    end else if (cmd.emit) begin
      interval_ms   <= 24'd0;
      entry_found   <= 1'b0;
      evicted_count <= evict_q;
    end
  end

  assign sts.point      = is_point;
  assign sts.sweep      = is_sweep;
  assign sts.grow       = grow_req;
  assign sts.sweep_last = (sweep_addr == IDX_W'(GROUPS - 1));
  assign sts.out_free   = out_free;

endmodule

FILE: bench/per_group_poll_backoff_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_group_poll_backoff_table_tb
// Drives query, report, reset, tick and sweep items through the backoff table
// under random idling on both sides, mirrors the table and its registers in a
// local model, and checks every result field against the model's prediction.
// ----------------------------------------------------------------------------
module per_group_poll_backoff_table_tb;

  localparam int          GROUP_COUNT  = 64;
  localparam int          QUIET_LIMIT  = 3000;
  localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
  localparam logic [23:0] DATA_ALL     = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] grp;
    logic       had;
  } poll_t;

  typedef struct packed {
    logic [23:0] ivl;
    logic        found;
    logic [6:0]  evicted;
  } backoff_result_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index     = pgpb_pkg::CFG_BASE_INTERVAL;
  logic [23:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [2:0]  operation     = pgpb_pkg::OP_QUERY;
  logic [5:0]  group_index   = '0;
  logic        got_messages  = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [23:0] interval_ms;
  logic        entry_found;
  logic [6:0]  evicted_count;

  per_group_poll_backoff_table #(.GROUPS(GROUP_COUNT)) uut (.*);

  // table mirror and register copies
  logic [23:0] base_ms    = pgpb_pkg::RST_BASE_INTERVAL;
  logic [15:0] thresh     = pgpb_pkg::RST_EMPTY_THRESH;
  logic [15:0] factor     = pgpb_pkg::RST_GROWTH_FACTOR;
  logic [23:0] ceil_ms    = pgpb_pkg::RST_MAX_INTERVAL;
  logic [15:0] idle_limit = pgpb_pkg::RST_MAX_IDLE;
  bit          live_tbl  [GROUP_COUNT];
  logic [23:0] ivl_tbl   [GROUP_COUNT];
  logic [15:0] empty_tbl [GROUP_COUNT];
  logic [31:0] touch_tbl [GROUP_COUNT];
  logic [31:0] secs       = '0;

  poll_t           pending_polls[$];
  backoff_result_t awaited_results[$];
  int              mismatches = 0;
  bit              idle_on    = 1'b1;
  int              send_gap   = 0;
  int              stall_left = 0;
  int              quiet      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [23:0] grown_interval(logic [23:0] iv);
    logic [39:0] prod;
    prod = ({16'd0, iv} * {24'd0, factor}) >> 8;
    if (prod > {16'd0, ceil_ms})
      prod = {16'd0, ceil_ms};
    return prod[23:0];
  endfunction

  function automatic backoff_result_t predict_backoff(poll_t p);
    backoff_result_t r;
    r = '0;
    case (p.op)
      pgpb_pkg::OP_TICK: secs = secs + 32'd1;
      pgpb_pkg::OP_SWEEP: begin
        for (int g = 0; g < GROUP_COUNT; g++)
          if (live_tbl[g] && (secs - touch_tbl[g]) > {16'd0, idle_limit}) begin
            live_tbl[g] = 1'b0;
            if (r.evicted < pgpb_pkg::EVICT_MAX)
              r.evicted++;
          end
      end
      pgpb_pkg::OP_QUERY, pgpb_pkg::OP_REPORT: begin
        r.found = live_tbl[p.grp];
        if (!r.found) begin
          live_tbl[p.grp]  = 1'b1;
          ivl_tbl[p.grp]   = base_ms;
          empty_tbl[p.grp] = '0;
        end
        touch_tbl[p.grp] = secs;
        if (p.op == pgpb_pkg::OP_REPORT) begin
          if (p.had) begin
            empty_tbl[p.grp] = '0;
            ivl_tbl[p.grp]   = base_ms;
          end else begin
            if (empty_tbl[p.grp] != pgpb_pkg::COUNT_MAX)
              empty_tbl[p.grp]++;
            if (empty_tbl[p.grp] >= thresh)
              ivl_tbl[p.grp] = grown_interval(ivl_tbl[p.grp]);
          end
        end
        r.ivl = ivl_tbl[p.grp];
      end
      pgpb_pkg::OP_RESET: begin
        r.found = live_tbl[p.grp];
        if (r.found) begin
          empty_tbl[p.grp] = '0;
          ivl_tbl[p.grp]   = base_ms;
          touch_tbl[p.grp] = secs;
          r.ivl            = base_ms;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin : feed_polls
    poll_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        awaited_results.insert(awaited_results.size(),
                               predict_backoff('{operation, group_index, got_messages}));
      if (!(in_valid && in_stall)) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (pending_polls.size() != 0) begin
          nxt = pending_polls.pop_front();
          operation    <= nxt.op;
          group_index  <= nxt.grp;
          got_messages <= nxt.had;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // monitor
  always @(posedge clk) begin : watch_results
    backoff_result_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, got %0d/%0d/%0d", $time,
                   interval_ms, entry_found, evicted_count);
        end else begin
          want = awaited_results.pop_front();
          check_field("interval_ms", want.ivl, interval_ms);
          check_field("entry_found", {23'd0, want.found}, {23'd0, entry_found});
          check_field("evicted_count", {17'd0, want.evicted}, {17'd0, evicted_count});
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 7);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("per_group_poll_backoff_table_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      pgpb_pkg::CFG_BASE_INTERVAL: base_ms    = data;
      pgpb_pkg::CFG_EMPTY_THRESH:  thresh     = data[15:0];
      pgpb_pkg::CFG_GROWTH_FACTOR: factor     = data[15:0];
      pgpb_pkg::CFG_MAX_INTERVAL:  ceil_ms    = data;
      pgpb_pkg::CFG_MAX_IDLE:      idle_limit = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [23:0] b, input logic [23:0] t, input logic [23:0] f,
                           input logic [23:0] m, input logic [23:0] i);
    write_reg(pgpb_pkg::CFG_BASE_INTERVAL, b);
    write_reg(pgpb_pkg::CFG_EMPTY_THRESH, t);
    write_reg(pgpb_pkg::CFG_GROWTH_FACTOR, f);
    write_reg(pgpb_pkg::CFG_MAX_INTERVAL, m);
    write_reg(pgpb_pkg::CFG_MAX_IDLE, i);
  endtask

  task automatic random_settings();
    logic [23:0] f;
    if ($urandom_range(0, 1) == 0)
      f = 24'($urandom);
    else
      f = {8'($urandom), 16'($urandom_range(200, 800))};
    write_all(24'($urandom_range(1, 5000)), {8'($urandom), 16'($urandom_range(0, 6))}, f,
              24'($urandom_range(1, (1 << 24) - 1)),
              {8'($urandom), 16'($urandom_range(0, 15))});
  endtask

  task automatic add_poll(input logic [2:0] op, input logic [5:0] grp, input logic had);
    poll_t p;
    p = '{op, grp, had};
    pending_polls.insert(pending_polls.size(), p);
  endtask

  task automatic add_random(input int count);
    poll_t       p;
    int unsigned pick;
    repeat (count) begin
      pick  = $urandom_range(0, 99);
      p.had = 1'($urandom);
      p.grp = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7)) : 6'($urandom);
      if (pick < 20) begin
        p.op = pgpb_pkg::OP_QUERY;
      end else if (pick < 62) begin
        p.op  = pgpb_pkg::OP_REPORT;
        p.had = ($urandom_range(0, 9) < 3);
      end else if (pick < 70) begin
        p.op = pgpb_pkg::OP_RESET;
      end else if (pick < 86) begin
        p.op = pgpb_pkg::OP_TICK;
      end else if (pick < 94) begin
        p.op = pgpb_pkg::OP_SWEEP;
      end else begin
        p.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      pending_polls.insert(pending_polls.size(), p);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_polls.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // defaults: growth from the third empty poll up to the ceiling
    add_poll(pgpb_pkg::OP_QUERY, 6'd0, 1'b0);
    add_poll(pgpb_pkg::OP_QUERY, 6'd0, 1'b1);
    repeat (8) add_poll(pgpb_pkg::OP_REPORT, 6'd0, 1'b0);
    add_poll(pgpb_pkg::OP_REPORT, 6'd0, 1'b1);
    add_poll(pgpb_pkg::OP_REPORT, 6'd63, 1'b0);
    add_poll(pgpb_pkg::OP_REPORT, 6'd62, 1'b1);
    add_poll(pgpb_pkg::OP_RESET, 6'd61, 1'b1);
    add_poll(pgpb_pkg::OP_RESET, 6'd63, 1'b0);
    add_poll(pgpb_pkg::OP_TICK, 6'd63, 1'b1);
    add_poll(pgpb_pkg::OP_SWEEP, 6'd63, 1'b1);
    for (int k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++)
      add_poll(3'(k), 6'd63, 1'b1);
    add_poll(pgpb_pkg::OP_QUERY, 6'd63, 1'b0);
    add_random(125);
    drain();
    add_random(125);
    drain();

    // minimum base, growth on every empty poll, largest factor, no idle time
    write_all(24'd1, 24'd0, DATA_ALL, DATA_ALL, 24'd0);
    for (int k = pgpb_pkg::CFG_MAX_IDLE + 1; k < 8; k++)
      write_reg(3'(k), 24'($urandom));
    add_poll(pgpb_pkg::OP_QUERY, 6'd1, 1'b0);
    repeat (6) add_poll(pgpb_pkg::OP_REPORT, 6'd1, 1'b0);
    add_poll(pgpb_pkg::OP_TICK, 6'd0, 1'b0);
    add_poll(pgpb_pkg::OP_SWEEP, 6'd0, 1'b0);
    add_poll(pgpb_pkg::OP_QUERY, 6'd1, 1'b0);
    add_random(250);
    drain();

    // largest base, smallest factor and ceiling: the interval shrinks to zero
    write_all(DATA_ALL, 24'hFF0001, 24'hFF0001, 24'd1, DATA_ALL);
    add_poll(pgpb_pkg::OP_REPORT, 6'd2, 1'b1);
    repeat (3) add_poll(pgpb_pkg::OP_REPORT, 6'd2, 1'b0);
    add_poll(pgpb_pkg::OP_RESET, 6'd2, 1'b0);
    add_random(250);
    drain();

    random_settings();
    add_random(200);
    drain();
    random_settings();
    add_random(200);
    drain();

    // slow growth, back to back with no idling
    idle_on = 1'b0;
    write_all(24'd1000, 24'd4, 24'd257, DATA_ALL, 24'd0);
    add_poll(pgpb_pkg::OP_REPORT, 6'd9, 1'b1);
    repeat (12) add_poll(pgpb_pkg::OP_REPORT, 6'd9, 1'b0);
    add_poll(pgpb_pkg::OP_QUERY, 6'd9, 1'b0);
    drain();

    random_settings();
    add_random(200);
    drain();
    repeat (80) @(posedge clk);

    if (mismatches == 0)
      $display("per_group_poll_backoff_table_tb OK");
    else
      $display("per_group_poll_backoff_table_tb NOT OK");
    $finish;
  end

endmodule
